@@ rtl/core/rrts_pkg.sv @@
// Shared types, codes and command/status bundles of the round-robin task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  // Fixed field widths of the transfer payloads.
  localparam int OP_W        = 3;
  localparam int ID_W        = 4;
  localparam int STATUS_W    = 3;
  localparam int TSTATE_W    = 2;
  localparam int TICK_OUT_W  = 32;
  localparam int COUNT_OUT_W = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [TSTATE_W-1:0] tstate_t;

  // Operation codes.
  localparam op_t OP_TICK  = 3'd0;
  localparam op_t OP_BOOT  = 3'd1;
  localparam op_t OP_ALLOC = 3'd2;
  localparam op_t OP_START = 3'd3;
  localparam op_t OP_VFORK = 3'd4;
  localparam op_t OP_EXIT  = 3'd5;
  localparam op_t OP_QUERY = 3'd6;

  // Result status codes.
  localparam status_t ERR_OK      = 3'd0;
  localparam status_t ERR_FULL    = 3'd1;
  localparam status_t ERR_BAD_ID  = 3'd2;
  localparam status_t ERR_NO_TASK = 3'd3;
  localparam status_t ERR_NO_RUN  = 3'd4;

  // Task states.
  localparam tstate_t TS_NEW     = 2'd0;
  localparam tstate_t TS_RUNNING = 2'd1;
  localparam tstate_t TS_WAITING = 2'd2;
  localparam tstate_t TS_ZOMBIE  = 2'd3;

  // Table address selects.
  typedef logic [2:0] addr_sel_t;
  localparam addr_sel_t ASEL_ID   = 3'd0;
  localparam addr_sel_t ASEL_CUR  = 3'd1;
  localparam addr_sel_t ASEL_PAR  = 3'd2;
  localparam addr_sel_t ASEL_NEW  = 3'd3;
  localparam addr_sel_t ASEL_SCAN = 3'd4;

  // Result task number selects.
  typedef logic [2:0] res_sel_t;
  localparam res_sel_t RSEL_ZERO = 3'd0;
  localparam res_sel_t RSEL_ID   = 3'd1;
  localparam res_sel_t RSEL_CUR  = 3'd2;
  localparam res_sel_t RSEL_NEW  = 3'd3;
  localparam res_sel_t RSEL_HIT  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ID_W-1:0]        result_id;
    logic [TSTATE_W-1:0]    task_state;
    logic [TICK_OUT_W-1:0]  tick_count;
    logic [COUNT_OUT_W-1:0] count_out;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      st_rd;
    logic      tk_rd;
    logic      par_rd;
    addr_sel_t rd_sel;
    logic      st_wr;
    addr_sel_t st_wr_sel;
    tstate_t   st_wr_val;
    logic      new_entry;
    logic      new_has_parent;
    logic      tk_incr;
    logic      set_cur_id;
    logic      set_cur_hit;
    logic      scan_init;
    logic      scan_step;
    logic      grab_cur_run;
    logic      res_load;
    res_sel_t  res_sel;
    logic      load_out;
    status_t   out_status;
    logic      out_query;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic have_cur;
    logic n_zero;
    logic full;
    logic id_bad;
    logic par_live;
    logic st_waiting;
    logic scan_hit;
    logic scan_end;
    logic cur_run;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/round_robin_task_scheduler.sv @@
// Top level of the round-robin task scheduler.
// The scheduler keeps a table of up to MAX_TASKS tasks, each with a state, a
// TICK_BITS wide wrapping tick count and a vfork parent, plus a current task
// and a count of allocated tasks. Each input transfer carries one operation
// (tick, boot, alloc, start, vfork, exit or query) and produces exactly one
// result transfer with a status, a task number, the queried state and tick
// count, and the task count after the operation. Items are handled one at a
// time. Boot, alloc, start, query, unused codes and every refused operation
// finish in the decode state. A successful vfork then marks the current task
// waiting, and a successful exit checks its vfork parent and, if that parent
// is live, reads its state and wakes it when it is waiting. A tick first
// updates the current task's tick count and then runs the round-robin search
// that reads the state memory one slot per cycle; it ends when a running task
// is found or every other allocated task has been checked. The result sits
// in an output register, so a new item is accepted while an earlier result
// still waits to be taken; the next result then waits until that one leaves.
// Table entries hold no reset value; they are defined once alloc or vfork has
// written them, and the block only reads entries that have been written.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TICK_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // The controller sequences each operation; the datapath holds the tables,
  // the current task, the scan counters and the result register.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrts_dp #(
    .MAX_TASKS (MAX_TASKS),
    .TICK_BITS (TICK_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

`ifndef ASSERT_OFF
  // Once an item is taken, the block works on it before taking another.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input transfer accepted while an item was in progress");

  // Only a successful query reports a task state or tick count.
  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != ERR_OK)) |->
      ((out_item.task_state == TS_NEW) && (out_item.tick_count == '0)))
    else $error("error result carries query fields");

  // A table-full answer is only given when every slot is allocated.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ERR_FULL)) |->
      (out_item.count_out == COUNT_OUT_W'(MAX_TASKS)))
    else $error("table full reported with free slots");
`endif

endmodule

`default_nettype wire

@@ rtl/core/rrts_ctrl.sv @@
// Sequencing state machine of the round-robin task scheduler.
`timescale 1ns / 1ps
`default_nettype none

module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_TK_UPD  = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_VF_PAR  = 3'd4;
  localparam logic [2:0] S_EX_PAR  = 3'd5;
  localparam logic [2:0] S_EX_WAKE = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  status_t    status_r, status_nxt;
  logic       query_r, query_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = ASEL_CUR;
    cmd.st_wr_sel = ASEL_CUR;
    cmd.res_sel   = RSEL_ZERO;
    cmd.out_status = status_r;
    cmd.out_query  = query_r;
    state_nxt     = state_r;
    status_nxt    = status_r;
    query_nxt     = query_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        status_nxt   = ERR_OK;
        query_nxt    = 1'b0;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RSEL_ZERO;
        state_nxt    = S_DONE;
        unique case (stat.op)
          OP_TICK: begin
            if (!stat.have_cur) begin
              status_nxt = ERR_NO_TASK;
            end else begin
              cmd.st_rd  = 1'b1;
              cmd.tk_rd  = 1'b1;
              cmd.rd_sel = ASEL_CUR;
              state_nxt  = S_TK_UPD;
            end
          end
          OP_BOOT: begin
            priority if (stat.n_zero) begin
              status_nxt = ERR_NO_TASK;
            end else if (stat.id_bad) begin
              status_nxt = ERR_BAD_ID;
            end else begin
              cmd.set_cur_id = 1'b1;
              cmd.res_sel    = RSEL_ID;
            end
          end
          OP_ALLOC: begin
            if (stat.full) begin
              status_nxt = ERR_FULL;
            end else begin
              cmd.new_entry = 1'b1;
              cmd.st_wr     = 1'b1;
              cmd.st_wr_sel = ASEL_NEW;
              cmd.st_wr_val = TS_NEW;
              cmd.res_sel   = RSEL_NEW;
            end
          end
          OP_START: begin
            if (stat.id_bad) begin
              status_nxt = ERR_BAD_ID;
            end else begin
              cmd.st_wr     = 1'b1;
              cmd.st_wr_sel = ASEL_ID;
              cmd.st_wr_val = TS_RUNNING;
              cmd.res_sel   = RSEL_ID;
            end
          end
          OP_VFORK: begin
            priority if (!stat.have_cur) begin
              status_nxt = ERR_NO_TASK;
            end else if (stat.full) begin
              status_nxt = ERR_FULL;
            end else begin
              cmd.new_entry      = 1'b1;
              cmd.new_has_parent = 1'b1;
              cmd.st_wr          = 1'b1;
              cmd.st_wr_sel      = ASEL_NEW;
              cmd.st_wr_val      = TS_RUNNING;
              cmd.res_sel        = RSEL_NEW;
              state_nxt          = S_VF_PAR;
            end
          end
          OP_EXIT: begin
            if (!stat.have_cur) begin
              status_nxt = ERR_NO_TASK;
            end else begin
              cmd.st_wr     = 1'b1;
              cmd.st_wr_sel = ASEL_CUR;
              cmd.st_wr_val = TS_ZOMBIE;
              cmd.par_rd    = 1'b1;
              cmd.res_sel   = RSEL_CUR;
              state_nxt     = S_EX_PAR;
            end
          end
          OP_QUERY: begin
            if (stat.id_bad) begin
              status_nxt = ERR_BAD_ID;
            end else begin
              cmd.st_rd   = 1'b1;
              cmd.tk_rd   = 1'b1;
              cmd.rd_sel  = ASEL_ID;
              cmd.res_sel = RSEL_ID;
              query_nxt   = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_TK_UPD: begin
        cmd.tk_incr      = 1'b1;
        cmd.grab_cur_run = 1'b1;
        cmd.scan_init    = 1'b1;
        state_nxt        = S_SCAN;
      end
      S_SCAN: begin
        priority if (stat.scan_hit) begin
          cmd.set_cur_hit = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_sel     = RSEL_HIT;
          state_nxt       = S_DONE;
        end else if (stat.scan_end) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RSEL_CUR;
          status_nxt   = stat.cur_run ? ERR_OK : ERR_NO_RUN;
          state_nxt    = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          cmd.st_rd     = 1'b1;
          cmd.rd_sel    = ASEL_SCAN;
        end
      end
      S_VF_PAR: begin
        cmd.st_wr     = 1'b1;
        cmd.st_wr_sel = ASEL_CUR;
        cmd.st_wr_val = TS_WAITING;
        state_nxt     = S_DONE;
      end
      S_EX_PAR: begin
        if (stat.par_live) begin
          cmd.st_rd  = 1'b1;
          cmd.rd_sel = ASEL_PAR;
          state_nxt  = S_EX_WAKE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EX_WAKE: begin
        if (stat.st_waiting) begin
          cmd.st_wr     = 1'b1;
          cmd.st_wr_sel = ASEL_PAR;
          cmd.st_wr_val = TS_RUNNING;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= ERR_OK;
      query_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      query_r     <= query_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rrts_dp.sv @@
// Task tables, current-task registers, scan counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module rrts_dp
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TICK_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_item
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

  op_t              op_r;
  logic [ID_W-1:0]  id_r;
  logic [IDX_W-1:0] cur_r;
  logic             cur_valid_r;
  logic [CNT_W-1:0] count_r;

  // Task tables: state, tick count, and {parent valid, parent slot}.
  tstate_t          st_mem  [MAX_TASKS];
  logic [TICK_BITS-1:0] tk_mem [MAX_TASKS];
  logic [IDX_W:0]   par_mem [MAX_TASKS];

  tstate_t              st_rdata_r;
  logic [TICK_BITS-1:0] tk_rdata_r;
  logic [IDX_W:0]       par_rdata_r;

  logic [IDX_W-1:0] iss_r, chk_slot_r;
  logic [CNT_W-1:0] left_r;
  logic             chk_v_r;
  logic             cur_run_r;
  logic [ID_W-1:0]  res_id_r;
  out_item_t        out_r;

  logic [IDX_W-1:0] id_idx, new_idx, par_idx;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [CNT_W-1:0] cur_inc, iss_inc;
  logic [IDX_W-1:0] cur_wrap_nxt, iss_wrap_nxt;

  assign id_idx  = IDX_W'(id_r);
  assign new_idx = IDX_W'(count_r);
  assign par_idx = par_rdata_r[IDX_W-1:0];

  // Round-robin successor of a slot among the allocated tasks.
  assign cur_inc      = CNT_W'(cur_r) + CNT_W'(1);
  assign iss_inc      = CNT_W'(iss_r) + CNT_W'(1);
  assign cur_wrap_nxt = (cur_inc == count_r) ? '0 : IDX_W'(cur_inc);
  assign iss_wrap_nxt = (iss_inc == count_r) ? '0 : IDX_W'(iss_inc);

  always_comb begin
    unique case (cmd.rd_sel)
      ASEL_ID:   rd_addr = id_idx;
      ASEL_CUR:  rd_addr = cur_r;
      ASEL_PAR:  rd_addr = par_idx;
      ASEL_NEW:  rd_addr = new_idx;
      ASEL_SCAN: rd_addr = iss_r;
      default:   rd_addr = cur_r;
    endcase
  end

  always_comb begin
    unique case (cmd.st_wr_sel)
      ASEL_ID:   wr_addr = id_idx;
      ASEL_CUR:  wr_addr = cur_r;
      ASEL_PAR:  wr_addr = par_idx;
      ASEL_NEW:  wr_addr = new_idx;
      ASEL_SCAN: wr_addr = iss_r;
      default:   wr_addr = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.st_wr) begin
      st_mem[wr_addr] <= cmd.st_wr_val;
    end
    if (cmd.st_rd) begin
      st_rdata_r <= st_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.new_entry) begin
      tk_mem[new_idx] <= '0;
    end else if (cmd.tk_incr) begin
      tk_mem[cur_r] <= tk_rdata_r + TICK_BITS'(1);
    end
    if (cmd.tk_rd) begin
      tk_rdata_r <= tk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.new_entry) begin
      par_mem[new_idx] <= {cmd.new_has_parent, cur_r};
    end
    if (cmd.par_rd) begin
      par_rdata_r <= par_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_r       <= '0;
      count_r     <= '0;
      chk_v_r     <= 1'b0;
    end else begin
      if (cmd.set_cur_id) begin
        cur_r       <= id_idx;
        cur_valid_r <= 1'b1;
      end else if (cmd.set_cur_hit) begin
        cur_r <= chk_slot_r;
      end
      if (cmd.new_entry) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.scan_init) begin
        chk_v_r <= 1'b0;
      end else if (cmd.scan_step) begin
        chk_v_r <= (left_r != '0);
      end
    end
  end

  // Input capture, scan pipeline and result registers: the scan reads one slot per cycle and checks it the cycle after.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_item.operation;
      id_r <= in_item.task_id;
    end
    if (cmd.scan_init) begin
      iss_r  <= cur_wrap_nxt;
      left_r <= count_r - CNT_W'(1);
    end else if (cmd.scan_step && (left_r != '0)) begin
      chk_slot_r <= iss_r;
      iss_r      <= iss_wrap_nxt;
      left_r     <= left_r - CNT_W'(1);
    end
    if (cmd.grab_cur_run) begin
      cur_run_r <= (st_rdata_r == TS_RUNNING);
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RSEL_ZERO: res_id_r <= '0;
        RSEL_ID:   res_id_r <= id_r;
        RSEL_CUR:  res_id_r <= ID_W'(cur_r);
        RSEL_NEW:  res_id_r <= ID_W'(count_r);
        RSEL_HIT:  res_id_r <= ID_W'(chk_slot_r);
        default:   res_id_r <= '0;
      endcase
    end
    if (cmd.load_out) begin
      out_r.status     <= cmd.out_status;
      out_r.result_id  <= res_id_r;
      out_r.task_state <= cmd.out_query ? st_rdata_r : TS_NEW;
      out_r.tick_count <= cmd.out_query ? TICK_OUT_W'(tk_rdata_r) : '0;
      out_r.count_out  <= COUNT_OUT_W'(count_r);
    end
  end

  assign out_item = out_r;

  always_comb begin
    stat.op         = op_r;
    stat.have_cur   = cur_valid_r && (count_r != '0) && (CNT_W'(cur_r) < count_r);
    stat.n_zero     = (count_r == '0);
    stat.full       = (count_r == CNT_W'(MAX_TASKS));
    stat.id_bad     = (CMP_W'(id_r) >= CMP_W'(count_r));
    stat.par_live   = par_rdata_r[IDX_W] && (CNT_W'(par_idx) < count_r);
    stat.st_waiting = (st_rdata_r == TS_WAITING);
    stat.scan_hit   = chk_v_r && (st_rdata_r == TS_RUNNING);
    stat.scan_end   = !chk_v_r && (left_r == '0);
    stat.cur_run    = cur_run_r;
  end

endmodule

`default_nettype wire
